// ----- hw/rtl/ttpo_pkg.sv -----
// Package for the tiled texture pixel offset block.
// Holds the tiling format codes, register indexes and the configuration struct.
// No dependencies.
`default_nettype none

package ttpo_pkg;

	localparam int CFG_DATA_W  = 14;
	localparam int CFG_INDEX_W = 2;
	localparam int OFFSET_W    = 32;

	// Tiling formats
	localparam logic [2:0] FMT_UIF_XOR = 3'd0;
	localparam logic [2:0] FMT_UIF     = 3'd1;
	localparam logic [2:0] FMT_UB_TWO  = 3'd2;
	localparam logic [2:0] FMT_UB_ONE  = 3'd3;
	localparam logic [2:0] FMT_LTILE   = 3'd4;

	// Register indexes on the configuration port
	localparam logic [CFG_INDEX_W-1:0] REG_FORMAT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PSIZE  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT = 2'd2;

	// Largest pixel size code; larger codes behave as this one.
	localparam logic [2:0] PSIZE_MAX = 3'd4;

	// Block row bit flipped in odd column groups of the UIF XOR format.
	localparam int UIF_FLIP_BIT = 4;

	typedef struct packed {
		logic [2:0]          fmt;        // tiling format
		logic [2:0]          psize;      // clamped log2 of bytes per pixel
		logic [1:0]          lw;         // log2 of microtile width
		logic [1:0]          lh;         // log2 of microtile height
		logic [OFFSET_W-1:0] col_stride; // (column height in blocks - 1) * 4
	} ttpo_cfg_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ttpo_cfg.sv -----
// Configuration registers of the tiled texture pixel offset block and the
// microtile shape and UIF column stride derived from them. Uses ttpo_pkg.
`default_nettype none

module ttpo_cfg (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	input  wire logic [ttpo_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [ttpo_pkg::CFG_DATA_W-1:0]    cfg_data,
	output ttpo_pkg::ttpo_cfg_t                     cfg
);
	import ttpo_pkg::*;

	logic [2:0]            fmt_q;
	logic [2:0]            psize_q;
	logic [CFG_DATA_W-1:0] height_q;

	logic [2:0]            psize;
	logic [1:0]            lw;
	logic [1:0]            lh;
	logic [CFG_DATA_W:0]   height_sum;
	logic [CFG_DATA_W:0]   blk_rows;
	logic [2:0]            blk_h_log2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= FMT_UIF_XOR;
			psize_q  <= 3'd2;
			height_q <= CFG_DATA_W'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FORMAT: fmt_q    <= cfg_data[2:0];
				REG_PSIZE:  psize_q  <= cfg_data[2:0];
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		psize = (psize_q > PSIZE_MAX) ? PSIZE_MAX : psize_q;
		case (psize) inside
			[3'd0:3'd1]: lw = 2'd3;
			[3'd2:3'd3]: lw = 2'd2;
			default:     lw = 2'd1;
		endcase
		case (psize) inside
			3'd0:        lh = 2'd3;
			[3'd1:3'd2]: lh = 2'd2;
			default:     lh = 2'd1;
		endcase
		// Column height in 256-byte blocks, rounded up.
		blk_h_log2 = 3'(lh) + 3'd1;
		height_sum = (CFG_DATA_W+1)'(height_q)
			+ (((CFG_DATA_W+1)'(1) << blk_h_log2) - (CFG_DATA_W+1)'(1));
		blk_rows   = height_sum >> blk_h_log2;

		cfg.fmt        = fmt_q;
		cfg.psize      = psize;
		cfg.lw         = lw;
		cfg.lh         = lh;
		cfg.col_stride = (OFFSET_W'(blk_rows) - OFFSET_W'(1)) << 2;
	end

endmodule

`default_nettype wire

// ----- hw/rtl/ttpo_addr.sv -----
// Offset datapath of the tiled texture pixel offset block: microtile, block
// and format-specific placement terms for one coordinate. Uses ttpo_pkg.
`default_nettype none

module ttpo_addr #(
	parameter int COORD_WIDTH = 13
) (
	input  wire ttpo_pkg::ttpo_cfg_t            cfg,
	input  wire logic [COORD_WIDTH-1:0]         pixel_x,
	input  wire logic [COORD_WIDTH-1:0]         pixel_y,
	output logic [ttpo_pkg::OFFSET_W-1:0]       byte_offset
);
	import ttpo_pkg::*;

	logic [2:0]             ux;
	logic [2:0]             uy;
	logic [7:0]             in_utile;
	logic [COORD_WIDTH-1:0] ut_col;
	logic [COORD_WIDTH-1:0] ut_row;
	logic [COORD_WIDTH-1:0] bx;
	logic [COORD_WIDTH-1:0] by;
	logic [COORD_WIDTH-1:0] by_uif;
	logic [COORD_WIDTH-1:0] grp;
	logic [7:0]             low_bits;
	logic [OFFSET_W-1:0]    uif_id;
	logic [OFFSET_W-1:0]    ub_id;
	logic [OFFSET_W-1:0]    lt_sum;

	always_comb begin
		// Position inside the microtile, stored in raster order.
		ux       = pixel_x[2:0] & ~(3'b111 << cfg.lw);
		uy       = pixel_y[2:0] & ~(3'b111 << cfg.lh);
		in_utile = (8'(ux) + (8'(uy) << cfg.lw)) << cfg.psize;

		ut_col = pixel_x >> cfg.lw;
		ut_row = pixel_y >> cfg.lh;
		bx     = ut_col >> 1;
		by     = ut_row >> 1;
		grp    = bx >> 2;

		// Microtile within the block sits at +64 for the right column and
		// +128 for the bottom row; the in-microtile offset stays below 64.
		low_bits = {ut_row[0], ut_col[0], in_utile[5:0]};

		by_uif = by;
		if (cfg.fmt == FMT_UIF_XOR && grp[0])
			by_uif[UIF_FLIP_BIT] = ~by[UIF_FLIP_BIT];

		uif_id = OFFSET_W'(grp) * cfg.col_stride + OFFSET_W'(bx) + (OFFSET_W'(by_uif) << 2);

		if (cfg.fmt == FMT_UB_TWO)
			ub_id = (OFFSET_W'(by) << 1) + OFFSET_W'(bx);
		else
			ub_id = OFFSET_W'(by) + OFFSET_W'(bx);

		lt_sum = OFFSET_W'(ut_col) + OFFSET_W'(ut_row);

		case (cfg.fmt)
			FMT_UIF_XOR, FMT_UIF:
				byte_offset = (uif_id << 8) + OFFSET_W'(low_bits);
			FMT_UB_TWO, FMT_UB_ONE:
				byte_offset = (ub_id << 8) + OFFSET_W'(low_bits);
			FMT_LTILE:
				byte_offset = (lt_sum << 6) + OFFSET_W'(in_utile[5:0]);
			default:
				byte_offset = '0;
		endcase
	end

endmodule

`default_nettype wire

// ----- hw/rtl/tiled_texture_pixel_offset_top.sv -----
// Tiled texture pixel offset block: input stage, offset datapath, result stage.
// An accepted input beat is registered in the input stage, then its offset in the result stage.
// Throughput: one beat per cycle while the result side is ready; the input register
// also advances whenever it is empty, so a held result still lets one more beat in.
// Reset clears the valid bits and returns the registers to format 0, 4-byte
// pixels and an image height of one. Depends on ttpo_pkg, ttpo_cfg, ttpo_addr.
`default_nettype none

module tiled_texture_pixel_offset_top #(
	parameter int COORD_WIDTH = 13
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Input beats
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// [COORD_WIDTH-1:0] pixel_x, [2*COORD_WIDTH-1:COORD_WIDTH] pixel_y, then zero fill
	input  wire logic [((2*COORD_WIDTH+7)/8)*8-1:0]  s_axis_tdata,
	// Result beats
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// [31:0] byte_offset
	output logic [ttpo_pkg::OFFSET_W-1:0]            m_axis_tdata,
	// Configuration writes
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [ttpo_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [ttpo_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import ttpo_pkg::*;

	ttpo_cfg_t              cfg;
	logic                   valid_s1;
	logic [COORD_WIDTH-1:0] pixel_x_s1;
	logic [COORD_WIDTH-1:0] pixel_y_s1;
	logic                   valid_s2;
	logic [OFFSET_W-1:0]    offset_s2;
	logic [OFFSET_W-1:0]    offset;
	logic                   adv_s2;
	logic                   adv_s1;

	assign cfg_ready = 1'b1;

	ttpo_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign adv_s1        = !valid_s1 || adv_s2;
	assign s_axis_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_axis_tvalid) begin
			pixel_x_s1 <= s_axis_tdata[COORD_WIDTH-1:0];
			pixel_y_s1 <= s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
		end
	end

	ttpo_addr #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_addr (
		.cfg         (cfg),
		.pixel_x     (pixel_x_s1),
		.pixel_y     (pixel_y_s1),
		.byte_offset (offset)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			offset_s2 <= offset;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = offset_s2;

	// An empty result stage must never hold off the input side.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> s_axis_tready)
		else $error("input stalled while result stage empty");

	// An accepted beat lands in the input stage.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> valid_s1)
		else $error("accepted beat lost at input stage");

	// A beat in the input stage moves on when the result stage advances.
	a_s1_moves_on: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2) |=> (valid_s2 && $stable(cfg.fmt) || valid_s2))
		else $error("beat dropped between stages");

	// A beat in the input stage with a stalled result stage is kept.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s2) |=> (valid_s1 && $stable(pixel_x_s1) && $stable(pixel_y_s1)))
		else $error("input stage beat changed while stalled");

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for the tiled texture pixel offset block.
// Drives pixel beats and register writes, predicts each byte offset in a scoreboard.
// Depends on ttpo_pkg and tiled_texture_pixel_offset_top.
`default_nettype none

module testbench;

	import ttpo_pkg::*;

	localparam int COORD_W   = 13;
	localparam int IN_W      = ((2*COORD_W+7)/8)*8;
	localparam int COORD_MAX = (1 << COORD_W) - 1;
	localparam int ITEMS_PER_PHASE = 50;
	localparam int RANDOM_PHASES   = 17;
	localparam int LONG_STALL      = 80;

	// The port decodes two index bits; this index names no register.
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] x;
	} pixel_t;

	class offset_scoreboard;
		bit [2:0]            fmt;
		bit [2:0]            psize;
		bit [CFG_DATA_W-1:0] height;
		bit [OFFSET_W-1:0]   pending_offsets[$];
		int                  errors;

		function new();
			fmt = FMT_UIF_XOR;
			psize = 3'd2;
			height = 1;
			errors = 0;
		endfunction

		function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_FORMAT: fmt = data[2:0];
				REG_PSIZE:  psize = data[2:0];
				REG_HEIGHT: height = data;
				default: ;
			endcase
		endfunction

		function bit [OFFSET_W-1:0] predict_offset(pixel_t p);
			bit [31:0] x, y, s, lw, lh, bx, by, bh, id, utile, quad;
			x = p.x;
			y = p.y;
			s = (psize > PSIZE_MAX) ? PSIZE_MAX : psize;
			lw = (s <= 1) ? 3 : (s <= 3) ? 2 : 1;
			lh = (s == 0) ? 3 : (s <= 2) ? 2 : 1;
			// Raster position inside the 64-byte microtile.
			utile = ((x & ((32'd1 << lw) - 1)) + ((y & ((32'd1 << lh) - 1)) << lw)) << s;
			// Which of the four microtiles of the 256-byte block.
			quad = (x[lw] ? 32'd64 : 32'd0) + (y[lh] ? 32'd128 : 32'd0);
			bx = x >> (lw + 1);
			by = y >> (lh + 1);
			case (fmt)
				FMT_UIF_XOR, FMT_UIF: begin
					if (fmt == FMT_UIF_XOR && bx[2])
						by[UIF_FLIP_BIT] = ~by[UIF_FLIP_BIT];
					bh = (height + (32'd1 << (lh + 1)) - 1) >> (lh + 1);
					id = (bx >> 2) * ((bh - 1) * 4) + bx + by * 4;
					return id * 256 + quad + utile;
				end
				FMT_UB_TWO: return 256 * (by * 2 + bx) + quad + utile;
				FMT_UB_ONE: return 256 * (by + bx) + quad + utile;
				FMT_LTILE:  return 64 * ((x >> lw) + (y >> lh)) + utile;
				default:    return 0;
			endcase
		endfunction

		function void note_pixel(pixel_t p);
			pending_offsets.push_back(predict_offset(p));
		endfunction

		function void check_offset(logic [OFFSET_W-1:0] actual);
			bit [OFFSET_W-1:0] expected;
			if (pending_offsets.size() == 0) begin
				$error("byte_offset: result beat with nothing pending, actual %08h", actual);
				errors++;
			end else begin
				expected = pending_offsets.pop_front();
				if (actual !== expected) begin
					$error("byte_offset: expected %08h, actual %08h", expected, actual);
					errors++;
				end
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	wire                    s_axis_tready;
	logic [IN_W-1:0]        s_axis_tdata = '0;
	wire                    m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	wire [OFFSET_W-1:0]     m_axis_tdata;
	logic                   cfg_valid = 1'b0;
	wire                    cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	offset_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int stall_request = 0;
	int stall_left = 0;

	tiled_texture_pixel_offset_top #(.COORD_WIDTH(COORD_W)) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #2 clk = ~clk;

	// Result side: random back-pressure, plus one long hold-off on request.
	always @(negedge clk) begin
		if (stall_request > 0) begin
			stall_left = stall_request;
			stall_request = 0;
		end
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else
			m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_offset(m_axis_tdata);
	end

	task automatic send_pixel(pixel_t p);
		int gap;
		logic [IN_W-1:0] word;
		gap = 0;
		while (gap < 20 && $urandom_range(0, 99) < send_idle_pct)
			gap++;
		word = '0;
		word[2*COORD_W-1:0] = p;
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= word;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_pixel(p);
	endtask

	// Stops offering pixels and waits until every offset has come back.
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.pending_offsets.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_register(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Origin, far corner, and a point that lands in an odd UIF column group.
	task automatic send_directed();
		pixel_t corners[3];
		corners[0] = '{x: 13'd0, y: 13'd0};
		corners[1] = '{x: COORD_W'(COORD_MAX), y: COORD_W'(COORD_MAX)};
		corners[2] = '{x: 13'h0E6, y: 13'h1F3};
		foreach (corners[i])
			send_pixel(corners[i]);
	endtask

	initial begin
		#1_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		pixel_t p;
		logic [2:0] fmt_code, psize_code;
		logic [CFG_DATA_W-1:0] height;

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed: reset settings first, then every format and size extreme.
		send_directed();
		write_reg(REG_PSIZE, 14'd0);
		write_reg(REG_HEIGHT, 14'd8192);
		write_reg(REG_FORMAT, CFG_DATA_W'(FMT_UIF_XOR));
		send_directed();
		write_reg(REG_FORMAT, CFG_DATA_W'(FMT_UIF));
		write_reg(REG_HEIGHT, 14'd0);
		write_reg(REG_PSIZE, 14'h3FFF);
		send_directed();
		write_reg(REG_FORMAT, CFG_DATA_W'(FMT_UB_TWO));
		write_reg(REG_PSIZE, CFG_DATA_W'(PSIZE_MAX));
		write_reg(REG_SPARE, 14'h2AAA);
		send_directed();
		write_reg(REG_FORMAT, CFG_DATA_W'(FMT_UB_ONE));
		write_reg(REG_PSIZE, 14'd1);
		send_directed();
		write_reg(REG_FORMAT, CFG_DATA_W'(FMT_LTILE));
		write_reg(REG_PSIZE, 14'd3);
		send_directed();
		// Unused format code, with junk in the upper data bits.
		write_reg(REG_FORMAT, {11'h7FF, FMT_LTILE + 3'd2});
		write_reg(REG_HEIGHT, 14'h3FFF);
		send_directed();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if ($urandom_range(0, 4) == 0)
				fmt_code = FMT_LTILE + 3'($urandom_range(1, 3));
			else
				fmt_code = 3'($urandom_range(0, 4));
			if ($urandom_range(0, 4) == 0)
				psize_code = PSIZE_MAX + 3'($urandom_range(1, 3));
			else
				psize_code = 3'($urandom_range(0, 4));
			case ($urandom_range(0, 5))
				0: height = 14'd1;
				1: height = 14'd8192;
				2: height = 14'd0;
				3: height = 14'h3FFF;
				4: height = 14'($urandom_range(1, 64));
				default: height = 14'($urandom_range(1, 8192));
			endcase
			write_reg(REG_FORMAT, {11'($urandom), fmt_code});
			write_reg(REG_PSIZE, {11'($urandom), psize_code});
			write_reg(REG_HEIGHT, height);

			if (phase < 6) begin
				send_idle_pct = 28;
				recv_idle_pct = 64;
			end else if (phase < 12) begin
				send_idle_pct = 64;
				recv_idle_pct = 28;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			// Hold the result side off while pixels keep coming, to back up the pipe.
			if (phase == 12)
				stall_request = LONG_STALL;

			repeat (ITEMS_PER_PHASE) begin
				case ($urandom_range(0, 3))
					0: p = '{x: COORD_W'($urandom), y: COORD_W'($urandom)};
					1: p = '{x: COORD_W'($urandom_range(0, 63)),
						y: COORD_W'($urandom_range(0, 63))};
					2: p = '{x: $urandom_range(0, 1) ? COORD_W'(COORD_MAX) : '0,
						y: $urandom_range(0, 1) ? COORD_W'(COORD_MAX) : '0};
					default: p = '{x: COORD_W'($urandom_range(0, 255)),
						y: COORD_W'($urandom)};
				endcase
				send_pixel(p);
			end
		end

		drain();
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
